// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define DMD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define DMD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define DMD_ASSERT_ALWAYS_NEXT(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dmd_pkg.sv =====
// Types, constants and helper functions of the dual mono detector.
`default_nettype none

package dmd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAG_W       = SAMPLE_BITS + 1;
    localparam int ACC_W       = 48;
    localparam int POS_W       = 40;
    localparam int NB_W        = 16;
    localparam int THR_W       = 17;
    localparam int MIN_W       = 32;
    localparam int WARN_W      = 10;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int SQ_SAT_BIT  = 24;

    localparam logic [WARN_W-1:0] PERMILLE = WARN_W'(1000);

    localparam logic ACT_PAIR  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_REGION  = 2'd1;
    localparam logic [1:0] KIND_TOTALS  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_LEN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARN      = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(66);
    localparam logic [MIN_W-1:0]  MIN_RESET  = MIN_W'(96000);
    localparam logic [WARN_W-1:0] WARN_RESET = '0;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          frame_last;
    } dmd_in_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic             frame_dual_mono;
        logic [POS_W-1:0] region_begin;
        logic [POS_W-1:0] region_finish;
        logic [POS_W-1:0] dual_mono_total;
        logic [POS_W-1:0] sample_total;
        logic             ratio_exceeded;
        logic             last;
    } dmd_out_t;

    // One finished frame or a flush, handed from front to back.
    typedef struct packed {
        logic             flush;
        logic [ACC_W-1:0] diff;
        logic [ACC_W-1:0] energy;
        logic [NB_W-1:0]  nb;
    } dmd_evt_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_q16;
        logic [MIN_W-1:0]  min_region_samples;
        logic [WARN_W-1:0] warn_ratio_tenths;
    } dmd_cfg_t;

    function automatic logic [MAG_W-1:0] abs_val(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic [ACC_W-1:0] sat_square(input logic [MAG_W-1:0] mag);
        logic [ACC_W-1:0]      m;
        logic [SQ_SAT_BIT-1:0] h;
        m = ACC_W'(mag);
        h = m[SQ_SAT_BIT-1:0];
        if (m[ACC_W-1:SQ_SAT_BIT] != '0) begin
            return '1;
        end
        return h * h;
    endfunction

    function automatic logic [ACC_W-1:0] add_sat48(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] add_sat40(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? '1 : s[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dmd_queue.sv =====
// Short event queue between the front and the back.
`default_nettype none

module dmd_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire dmd_pkg::dmd_evt_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output dmd_pkg::dmd_evt_t      pop_data,
    output logic                   not_empty
);
    import dmd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    dmd_evt_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full      = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmd_front.sv =====
// Front: accepts sample pairs, squares and accumulates them, closes frames.
`default_nettype none

module dmd_front #(
    parameter int MAX_FRAME_SAMPLES = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dmd_pkg::dmd_in_t  s_data,
    input  wire logic              q_full,
    output logic                   evt_push,
    output dmd_pkg::dmd_evt_t      evt_data
);
    import dmd_pkg::*;

    localparam int FL_W = $clog2(MAX_FRAME_SAMPLES + 1);

    typedef struct packed {
        logic             flush;
        logic             fend;
        logic [NB_W-1:0]  nb;
        logic [MAG_W-1:0] mag_l;
        logic [MAG_W-1:0] mag_r;
        logic [MAG_W-1:0] mag_d;
    } s1_t;

    typedef struct packed {
        logic             flush;
        logic             fend;
        logic [NB_W-1:0]  nb;
        logic [ACC_W-1:0] sq_l;
        logic [ACC_W-1:0] sq_r;
        logic [ACC_W-1:0] sq_d;
    } s2_t;

    typedef struct packed {
        logic             flush;
        logic             fend;
        logic [NB_W-1:0]  nb;
        logic [ACC_W-1:0] e_pair;
        logic [ACC_W-1:0] sq_d;
    } s3_t;

    logic adv;
    logic accept;

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t                     s1_reg;
    s2_t                     s2_reg;
    s3_t                     s3_reg;
    s1_t                     s1_next;
    logic [FL_W-1:0]         frame_len_reg;
    logic [FL_W-1:0]         nb;
    logic [ACC_W-1:0]        diff_acc_reg, energy_acc_reg;
    logic [ACC_W-1:0]        sum_d, sum_e;
    logic signed [MAG_W-1:0] l_ext, r_ext, d_ext;

    // Whole front holds while the queue is full.
    assign adv     = !q_full;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    always_comb begin
        l_ext = MAG_W'(s_data.left_sample);
        r_ext = MAG_W'(s_data.right_sample);
        d_ext = l_ext - r_ext;
        nb    = frame_len_reg + FL_W'(1);

        s1_next.flush = s_data.action == ACT_FLUSH;
        s1_next.fend  = s_data.frame_last || (nb == FL_W'(MAX_FRAME_SAMPLES));
        s1_next.nb    = NB_W'(nb);
        s1_next.mag_l = abs_val(l_ext);
        s1_next.mag_r = abs_val(r_ext);
        s1_next.mag_d = abs_val(d_ext);
    end

    always_comb begin
        sum_d = add_sat48(diff_acc_reg, s3_reg.sq_d);
        sum_e = add_sat48(energy_acc_reg, s3_reg.e_pair);

        evt_push        = adv && s3_valid_reg && (s3_reg.flush || s3_reg.fend);
        evt_data.flush  = s3_reg.flush;
        evt_data.diff   = sum_d;
        evt_data.energy = sum_e;
        evt_data.nb     = s3_reg.nb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            frame_len_reg  <= '0;
            diff_acc_reg   <= '0;
            energy_acc_reg <= '0;
        end else if (adv) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (accept) begin
                // Drop the partial frame on flush; restart the count at frame end.
                if (s1_next.flush || s1_next.fend) begin
                    frame_len_reg <= '0;
                end else begin
                    frame_len_reg <= nb;
                end
            end
            if (s3_valid_reg) begin
                if (s3_reg.flush || s3_reg.fend) begin
                    diff_acc_reg   <= '0;
                    energy_acc_reg <= '0;
                end else begin
                    diff_acc_reg   <= sum_d;
                    energy_acc_reg <= sum_e;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next;

            s2_reg.flush <= s1_reg.flush;
            s2_reg.fend  <= s1_reg.fend;
            s2_reg.nb    <= s1_reg.nb;
            s2_reg.sq_l  <= sat_square(s1_reg.mag_l);
            s2_reg.sq_r  <= sat_square(s1_reg.mag_r);
            s2_reg.sq_d  <= sat_square(s1_reg.mag_d);

            s3_reg.flush  <= s2_reg.flush;
            s3_reg.fend   <= s2_reg.fend;
            s3_reg.nb     <= s2_reg.nb;
            s3_reg.e_pair <= add_sat48(s2_reg.sq_l, s2_reg.sq_r);
            s3_reg.sq_d   <= s2_reg.sq_d;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmd_back.sv =====
// Back: frame verdicts, region tracking, stream totals and the result buffer.
`default_nettype none

module dmd_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dmd_pkg::dmd_cfg_t cfg,
    input  wire logic              evt_valid,
    input  wire dmd_pkg::dmd_evt_t evt_data,
    output logic                   evt_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dmd_pkg::dmd_out_t      m_data
);
    import dmd_pkg::*;

    localparam int LO_W   = 32;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int PLO_W  = THR_W + LO_W;
    localparam int PHI_W  = THR_W + HI_W;
    localparam int LHS_W  = ACC_W + 16;
    localparam int RHS_W  = PHI_W + LO_W;
    localparam int PHIGH  = POS_W - LO_W;
    localparam int TLO_W  = WARN_W + LO_W;
    localparam int THI_W  = WARN_W + PHIGH;
    localparam int TSUM_W = THI_W + LO_W;

    typedef struct packed {
        logic             flush;
        logic             ez;
        logic [LHS_W-1:0] lhs;
        logic [PLO_W-1:0] p_lo;
        logic [PHI_W-1:0] p_hi;
        logic [POS_W-1:0] pos_before;
        logic [POS_W-1:0] pos_after;
        logic [NB_W-1:0]  nb;
    } v1_t;

    typedef struct packed {
        logic             flush;
        logic             ez;
        logic [LHS_W-1:0] lhs;
        logic [RHS_W-1:0] rhs;
        logic [POS_W-1:0] pos_before;
        logic [POS_W-1:0] pos_after;
        logic [NB_W-1:0]  nb;
    } v2_t;

    typedef struct packed {
        logic             flush;
        logic             dual;
        logic [POS_W-1:0] pos_before;
        logic [POS_W-1:0] pos_after;
        logic [NB_W-1:0]  nb;
    } v3_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_SUM,
        ST_EMIT
    } state_t;

    // Verdict pipeline.
    logic             back_adv;
    logic             v1_valid_reg, v2_valid_reg, v3_valid_reg;
    v1_t              v1_reg;
    v2_t              v2_reg;
    v3_t              v3_reg;
    logic [POS_W-1:0] ss_reg;
    logic [POS_W-1:0] ss_after;

    // Region and totals state, result buffer.
    state_t           st_reg, st_next;
    logic             in_region_reg, in_region_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] dual_tot_reg, dual_tot_next;
    logic [POS_W-1:0] tot_d_reg, tot_d_next;
    logic [POS_W-1:0] tot_s_reg, tot_s_next;
    logic [TLO_W-1:0] a_lo_reg, a_lo_next, b_lo_reg, b_lo_next;
    logic [THI_W-1:0] a_hi_reg, a_hi_next, b_hi_reg, b_hi_next;
    logic [TSUM_W-1:0] a_sum_reg, a_sum_next, b_sum_reg, b_sum_next;
    dmd_out_t         slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0]       cnt_reg, cnt_next;

    logic             out_pop;
    logic             room;
    logic             u_take;
    logic [POS_W-1:0] start_eff;
    logic             long_region;
    logic             has_tot;
    dmd_out_t         r0, r1;
    logic [1:0]       n_push;

    assign out_pop  = m_valid && m_ready;
    assign room     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_pop);
    assign u_take   = v3_valid_reg && st_reg == ST_RUN && room;
    assign back_adv = !v3_valid_reg || u_take;
    assign evt_pop  = back_adv && evt_valid;
    assign m_valid  = cnt_reg != 2'd0;
    assign m_data   = slot0_reg;
    assign ss_after = add_sat40(ss_reg, POS_W'(evt_data.nb));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
            ss_reg       <= '0;
        end else if (back_adv) begin
            v1_valid_reg <= evt_pop;
            v2_valid_reg <= v1_valid_reg;
            v3_valid_reg <= v2_valid_reg;
            if (evt_pop) begin
                ss_reg <= evt_data.flush ? '0 : ss_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (back_adv) begin
            v1_reg.flush      <= evt_data.flush;
            v1_reg.ez         <= evt_data.energy == '0;
            v1_reg.lhs        <= {evt_data.diff, 16'b0};
            v1_reg.p_lo       <= PLO_W'(cfg.threshold_q16) * PLO_W'(evt_data.energy[LO_W-1:0]);
            v1_reg.p_hi       <= PHI_W'(cfg.threshold_q16) *
                                 PHI_W'(evt_data.energy[ACC_W-1:LO_W]);
            v1_reg.pos_before <= ss_reg;
            v1_reg.pos_after  <= evt_data.flush ? ss_reg : ss_after;
            v1_reg.nb         <= evt_data.nb;

            v2_reg.flush      <= v1_reg.flush;
            v2_reg.ez         <= v1_reg.ez;
            v2_reg.lhs        <= v1_reg.lhs;
            v2_reg.rhs        <= {v1_reg.p_hi, {LO_W{1'b0}}} + RHS_W'(v1_reg.p_lo);
            v2_reg.pos_before <= v1_reg.pos_before;
            v2_reg.pos_after  <= v1_reg.pos_after;
            v2_reg.nb         <= v1_reg.nb;

            v3_reg.flush      <= v2_reg.flush;
            v3_reg.dual       <= v2_reg.ez || (RHS_W'(v2_reg.lhs) < v2_reg.rhs);
            v3_reg.pos_before <= v2_reg.pos_before;
            v3_reg.pos_after  <= v2_reg.pos_after;
            v3_reg.nb         <= v2_reg.nb;
        end
    end

    always_comb begin
        st_next        = st_reg;
        in_region_next = in_region_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        len_next       = len_reg;
        dual_tot_next  = dual_tot_reg;
        tot_d_next     = tot_d_reg;
        tot_s_next     = tot_s_reg;
        a_lo_next      = a_lo_reg;
        a_hi_next      = a_hi_reg;
        b_lo_next      = b_lo_reg;
        b_hi_next      = b_hi_reg;
        a_sum_next     = a_sum_reg;
        b_sum_next     = b_sum_reg;
        slot0_next     = slot0_reg;
        slot1_next     = slot1_reg;
        cnt_next       = cnt_reg;
        r0             = '0;
        r1             = '0;
        n_push         = 2'd0;

        start_eff   = in_region_reg ? start_reg : v3_reg.pos_before;
        long_region = len_reg >= POS_W'(cfg.min_region_samples);
        has_tot     = v3_reg.pos_before != '0;

        case (st_reg)
            ST_RUN: begin
                if (u_take) begin
                    if (!v3_reg.flush) begin
                        r0.result_kind     = KIND_VERDICT;
                        r0.frame_dual_mono = v3_reg.dual;
                        r0.last            = 1'b1;
                        n_push             = 2'd1;
                        if (v3_reg.dual) begin
                            in_region_next = 1'b1;
                            start_next     = start_eff;
                            end_next       = v3_reg.pos_after;
                            len_next       = v3_reg.pos_after - start_eff;
                            dual_tot_next  = add_sat40(dual_tot_reg, POS_W'(v3_reg.nb));
                        end else if (in_region_reg) begin
                            // Run ended: report it when long enough.
                            in_region_next = 1'b0;
                            if (long_region) begin
                                r0.last          = 1'b0;
                                r1.result_kind   = KIND_REGION;
                                r1.region_begin  = start_reg;
                                r1.region_finish = end_reg;
                                r1.last          = 1'b1;
                                n_push           = 2'd2;
                            end
                        end
                    end else begin
                        if (in_region_reg && long_region) begin
                            r0.result_kind   = KIND_REGION;
                            r0.region_begin  = start_reg;
                            r0.region_finish = end_reg;
                            r0.last          = !has_tot;
                            n_push           = 2'd1;
                        end
                        if (has_tot) begin
                            tot_d_next = dual_tot_reg;
                            tot_s_next = v3_reg.pos_before;
                            st_next    = ST_MUL;
                        end
                        in_region_next = 1'b0;
                        start_next     = '0;
                        end_next       = '0;
                        len_next       = '0;
                        dual_tot_next  = '0;
                    end
                end
            end
            ST_MUL: begin
                a_lo_next = TLO_W'(PERMILLE) * TLO_W'(tot_d_reg[LO_W-1:0]);
                a_hi_next = THI_W'(PERMILLE) * THI_W'(tot_d_reg[POS_W-1:LO_W]);
                b_lo_next = TLO_W'(cfg.warn_ratio_tenths) * TLO_W'(tot_s_reg[LO_W-1:0]);
                b_hi_next = THI_W'(cfg.warn_ratio_tenths) * THI_W'(tot_s_reg[POS_W-1:LO_W]);
                st_next   = ST_SUM;
            end
            ST_SUM: begin
                a_sum_next = {a_hi_reg, {LO_W{1'b0}}} + TSUM_W'(a_lo_reg);
                b_sum_next = {b_hi_reg, {LO_W{1'b0}}} + TSUM_W'(b_lo_reg);
                st_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (room) begin
                    r0.result_kind     = KIND_TOTALS;
                    r0.dual_mono_total = tot_d_reg;
                    r0.sample_total    = tot_s_reg;
                    r0.ratio_exceeded  = (cfg.warn_ratio_tenths != '0) &&
                                         (a_sum_reg >= b_sum_reg);
                    r0.last            = 1'b1;
                    n_push             = 2'd1;
                    st_next            = ST_RUN;
                end
            end
            default: begin
                st_next = ST_RUN;
            end
        endcase

        // Push only into an emptied buffer; otherwise advance on a pop.
        if (n_push != 2'd0) begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = n_push;
        end else if (out_pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_RUN;
            in_region_reg <= 1'b0;
            start_reg     <= '0;
            end_reg       <= '0;
            len_reg       <= '0;
            dual_tot_reg  <= '0;
            cnt_reg       <= 2'd0;
        end else begin
            st_reg        <= st_next;
            in_region_reg <= in_region_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            len_reg       <= len_next;
            dual_tot_reg  <= dual_tot_next;
            cnt_reg       <= cnt_next;
        end
        tot_d_reg <= tot_d_next;
        tot_s_reg <= tot_s_next;
        a_lo_reg  <= a_lo_next;
        a_hi_reg  <= a_hi_next;
        b_lo_reg  <= b_lo_next;
        b_hi_reg  <= b_hi_next;
        a_sum_reg <= a_sum_next;
        b_sum_reg <= b_sum_next;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ===== rtl/dual_mono_detector.sv =====
// Top level of the dual mono detector: configuration registers and the two halves.
//
//  channel  dir  handshake        payload
//  s_       in   s_valid/s_ready  dmd_in_t  (sample pair or flush)
//  m_       out  m_valid/m_ready  dmd_out_t (verdict, region report or totals)
//  cfg_     in   cfg_we           cfg_addr selects the register, cfg_wdata holds it
//
// One transaction per cycle is taken on s_ while the event queue is not full; a frame's
// verdict goes through s1-s3, the event queue, v1-v3 and the output buffer to m_.
// A result pair (verdict plus region report) leaves the output buffer as two transfers.
// A flush with samples computes the totals in a multiply/add/compare sequence.
// Reset clears the stream state and loads the register defaults; there is no clearing pass.
// A stall on m_ backs up the back half, then the event queue, then s_ready.
`default_nettype none

module dual_mono_detector #(
    parameter int MAX_FRAME_SAMPLES = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire dmd_pkg::dmd_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output dmd_pkg::dmd_out_t                      m_data,
    input  wire logic                              cfg_we,
    input  wire logic [dmd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [dmd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import dmd_pkg::*;

    dmd_cfg_t cfg_reg;
    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_not_empty;
    dmd_evt_t q_in;
    dmd_evt_t q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_q16      <= THR_RESET;
            cfg_reg.min_region_samples <= MIN_RESET;
            cfg_reg.warn_ratio_tenths  <= WARN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_THRESHOLD: cfg_reg.threshold_q16      <= cfg_wdata[THR_W-1:0];
                CFG_MIN_LEN:   cfg_reg.min_region_samples <= cfg_wdata[MIN_W-1:0];
                CFG_WARN:      cfg_reg.warn_ratio_tenths  <= cfg_wdata[WARN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dmd_front #(
        .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .evt_push (q_push),
        .evt_data (q_in)
    );

    dmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    dmd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .evt_valid (q_not_empty),
        .evt_data  (q_out),
        .evt_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/dmd_checker.sv =====
// Port-level checks of the dual mono detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dmd_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire dmd_pkg::dmd_out_t m_data
);
    import dmd_pkg::*;

    `DMD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    `DMD_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_valid, "result valid after reset")

    `DMD_ASSERT_IMPLY(a_totals, aclk, aresetn, m_valid && m_data.result_kind == KIND_TOTALS, m_data.last && m_data.dual_mono_total <= m_data.sample_total, "bad totals result")

    `DMD_ASSERT_IMPLY(a_region, aclk, aresetn, m_valid && m_data.result_kind == KIND_REGION, m_data.region_finish >= m_data.region_begin && !m_data.frame_dual_mono, "bad region report")

    `DMD_ASSERT_IMPLY(a_verdict, aclk, aresetn, m_valid && m_data.result_kind == KIND_VERDICT, m_data.region_begin == '0 && m_data.sample_total == '0 && !m_data.ratio_exceeded, "verdict carries foreign fields")

endmodule

bind dual_mono_detector dmd_checker u_dmd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== verif/tb_dual_mono_detector.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the dual mono detector: directed table, then random streams.
module tb_dual_mono_detector;
    import dmd_pkg::*;

    localparam int FRAME_MAX = 4096;
    localparam int SETTLE    = 24;
    localparam int IDLE_PCT  = 21;

    localparam logic [ACC_W-1:0] ACC_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [POS_W-1:0] POS_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [51:0]      WARN_SCALE = 52'd1000;

    typedef enum int {
        MODE_SAME, MODE_NEAR, MODE_FREE, MODE_ZERO, MODE_MIRROR, MODE_QUIET, MODE_RAIL
    } pair_mode_e;

    typedef struct {
        dmd_in_t  item;
        bit       typed;
        int       n_typed;
        dmd_out_t res;
    } row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    dmd_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    dmd_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state and register copies.
    logic [THR_W-1:0]  thr_q16     = THR_RESET;
    logic [MIN_W-1:0]  min_len     = MIN_RESET;
    logic [WARN_W-1:0] warn_tenths = WARN_RESET;
    logic [ACC_W-1:0]  diff_sum, energy_sum;
    logic [15:0]       pairs_in_frame;
    logic              region_open;
    logic [POS_W-1:0]  region_start, region_end, sample_count, dual_count;

    dmd_out_t pending_results[$];
    dmd_out_t step_out[$];
    row_t     rows[$];
    int       mismatches = 0;
    int       items_sent = 0;
    bit       idle_on    = 1'b1;

    dual_mono_detector #(.MAX_FRAME_SAMPLES(FRAME_MAX)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [ACC_W-1:0] sum48(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
        return (a > ACC_MAX - b) ? ACC_MAX : a + b;
    endfunction

    function automatic logic [POS_W-1:0] sum40(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
        return (a > POS_MAX - b) ? POS_MAX : a + b;
    endfunction

    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        return (v < 0) ? 17'(-v) : 17'(v);
    endfunction

    // Magnitudes stay below 2^17, so the square never reaches the saturation point.
    function automatic logic [ACC_W-1:0] square17(input logic [16:0] m);
        return ACC_W'(m) * ACC_W'(m);
    endfunction

    function automatic dmd_out_t mk_result(input logic [1:0] kind, input logic dm,
                                           input logic [POS_W-1:0] b, input logic [POS_W-1:0] f,
                                           input logic [POS_W-1:0] dt,
                                           input logic [POS_W-1:0] st, input logic re);
        dmd_out_t r;
        r                 = '0;
        r.result_kind     = kind;
        r.frame_dual_mono = dm;
        r.region_begin    = b;
        r.region_finish   = f;
        r.dual_mono_total = dt;
        r.sample_total    = st;
        r.ratio_exceeded  = re;
        return r;
    endfunction

    function automatic dmd_out_t mk_verdict(input logic dm);
        dmd_out_t r;
        r      = mk_result(KIND_VERDICT, dm, '0, '0, '0, '0, 1'b0);
        r.last = 1'b1;
        return r;
    endfunction

    function automatic dmd_in_t mk_pair(input logic [15:0] l, input logic [15:0] r,
                                        input logic fl);
        dmd_in_t it;
        it.action       = ACT_PAIR;
        it.left_sample  = l;
        it.right_sample = r;
        it.frame_last   = fl;
        return it;
    endfunction

    // Sample fields and frame_last carry junk on a flush.
    function automatic dmd_in_t mk_flush();
        dmd_in_t it;
        it.action       = ACT_FLUSH;
        it.left_sample  = 16'($urandom);
        it.right_sample = 16'($urandom);
        it.frame_last   = 1'($urandom);
        return it;
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) begin
            return $urandom_range(1, 8);
        end else if (p < 95) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(41, 200);
    endfunction

    task automatic clear_stream();
        diff_sum       = '0;
        energy_sum     = '0;
        pairs_in_frame = '0;
        region_open    = 1'b0;
        region_start   = '0;
        region_end     = '0;
        sample_count   = '0;
        dual_count     = '0;
    endtask

    task automatic close_region();
        if (region_end - region_start >= POS_W'(min_len)) begin
            step_out.push_back(mk_result(KIND_REGION, 1'b0, region_start, region_end,
                                         '0, '0, 1'b0));
        end
    endtask

    // Work out the results one accepted transaction causes, into step_out.
    task automatic detect_step(input dmd_in_t it);
        logic signed [15:0] lv, rv;
        logic signed [16:0] lx, rx, dx;
        logic [16:0]        nb;
        logic [65:0]        lhs, rhs;
        logic [51:0]        dual_scaled, warn_scaled;
        logic               dual, warn;
        step_out.delete();
        if (it.action == ACT_FLUSH) begin
            if (region_open) begin
                region_end = sample_count;
                close_region();
            end
            if (sample_count != '0) begin
                dual_scaled = 52'(dual_count) * WARN_SCALE;
                warn_scaled = 52'(warn_tenths) * 52'(sample_count);
                warn        = (warn_tenths != '0) && (dual_scaled >= warn_scaled);
                step_out.push_back(mk_result(KIND_TOTALS, 1'b0, '0, '0, dual_count,
                                             sample_count, warn));
            end
            clear_stream();
        end else begin
            lv         = it.left_sample;
            rv         = it.right_sample;
            lx         = lv;
            rx         = rv;
            dx         = lx - rx;
            diff_sum   = sum48(diff_sum, square17(mag17(dx)));
            energy_sum = sum48(energy_sum, sum48(square17(mag17(lx)), square17(mag17(rx))));
            nb         = 17'(pairs_in_frame) + 17'd1;
            if (!it.frame_last && nb < FRAME_MAX) begin
                pairs_in_frame = nb[15:0];
            end else begin
                lhs  = {2'b00, diff_sum, 16'h0000};
                rhs  = 66'(thr_q16) * 66'(energy_sum);
                dual = (energy_sum == '0) || (lhs < rhs);
                step_out.push_back(mk_result(KIND_VERDICT, dual, '0, '0, '0, '0, 1'b0));
                if (dual) begin
                    if (!region_open) begin
                        region_open  = 1'b1;
                        region_start = sample_count;
                    end
                    region_end = sum40(sample_count, POS_W'(nb));
                    dual_count = sum40(dual_count, POS_W'(nb));
                end else if (region_open) begin
                    region_open = 1'b0;
                    close_region();
                end
                sample_count   = sum40(sample_count, POS_W'(nb));
                diff_sum       = '0;
                energy_sum     = '0;
                pairs_in_frame = '0;
            end
        end
        if (step_out.size() != 0) begin
            step_out[step_out.size()-1].last = 1'b1;
        end
    endtask

    task automatic push_step();
        foreach (step_out[k]) begin
            pending_results.push_back(step_out[k]);
        end
    endtask

    // Hold valid and payload until the transaction is taken; valid stays up afterwards.
    task automatic send_item(input dmd_in_t it);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic send_checked(input dmd_in_t it);
        send_item(it);
        detect_step(it);
        push_step();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [THR_W-1:0] thr, input logic [MIN_W-1:0] mn,
                                input logic [WARN_W-1:0] wr);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(thr);
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_LEN;
        cfg_wdata <= CFG_DATA_W'(mn);
        @(posedge aclk);
        cfg_addr  <= CFG_WARN;
        cfg_wdata <= CFG_DATA_W'(wr);
        @(posedge aclk);
        cfg_we      <= 1'b0;
        thr_q16     = thr;
        min_len     = mn;
        warn_tenths = wr;
    endtask

    task automatic send_frame(input int len, input pair_mode_e mode);
        int l, r;
        for (int i = 0; i < len; i++) begin
            case (mode)
                MODE_SAME: begin
                    l = rand16();
                    r = l;
                end
                MODE_NEAR: begin
                    l = rand16();
                    r = clamp16(l + int'($urandom_range(0, 6)) - 3);
                end
                MODE_FREE: begin
                    l = rand16();
                    r = rand16();
                end
                MODE_ZERO: begin
                    l = 0;
                    r = 0;
                end
                MODE_MIRROR: begin
                    l = rand16();
                    r = clamp16(-l);
                end
                MODE_QUIET: begin
                    l = int'($urandom_range(0, 8)) - 4;
                    r = int'($urandom_range(0, 8)) - 4;
                end
                default: begin
                    l = $urandom_range(0, 1) ? 32767 : -32768;
                    r = $urandom_range(0, 1) ? 32767 : -32768;
                end
            endcase
            send_checked(mk_pair(l[15:0], r[15:0], i == len - 1));
        end
    endtask

    // Mostly runs of matching frames broken by a random one; some flushes and junk.
    task automatic random_run(input int count);
        int         stop, p, n;
        pair_mode_e mode;
        stop = items_sent + count;
        while (items_sent < stop) begin
            p = $urandom_range(0, 99);
            if (p < 3) begin
                send_checked(mk_flush());
            end else if (p < 5) begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    send_checked(mk_pair(16'($urandom), 16'($urandom), 1'b0));
                end
                send_checked(mk_flush());
            end else if (p < 6) begin
                wait_drained();
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0, 1:    mode = MODE_SAME;
                        2:       mode = MODE_NEAR;
                        default: mode = MODE_ZERO;
                    endcase
                    send_frame(pick_len(), mode);
                end
                send_frame(pick_len(), pair_mode_e'($urandom_range(MODE_NEAR, MODE_RAIL)));
            end
        end
    endtask

    task automatic add_row(input dmd_in_t it, input bit typed, input int n,
                           input dmd_out_t res);
        row_t row;
        row.item    = it;
        row.typed   = typed;
        row.n_typed = n;
        row.res     = res;
        rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int field_diff(input string name, input logic [POS_W-1:0] want,
                                      input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch_results
        dmd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none got %p",
                         $time, m_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                mismatches += field_diff("result_kind", POS_W'(want.result_kind),
                                         POS_W'(m_data.result_kind));
                mismatches += field_diff("frame_dual_mono", POS_W'(want.frame_dual_mono),
                                         POS_W'(m_data.frame_dual_mono));
                mismatches += field_diff("region_begin", want.region_begin,
                                         m_data.region_begin);
                mismatches += field_diff("region_finish", want.region_finish,
                                         m_data.region_finish);
                mismatches += field_diff("dual_mono_total", want.dual_mono_total,
                                         m_data.dual_mono_total);
                mismatches += field_diff("sample_total", want.sample_total,
                                         m_data.sample_total);
                mismatches += field_diff("ratio_exceeded", POS_W'(want.ratio_exceeded),
                                         POS_W'(m_data.ratio_exceeded));
                mismatches += field_diff("last", POS_W'(want.last), POS_W'(m_data.last));
            end
        end
    end

    initial begin
        int l;
        clear_stream();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values apply throughout the table.
        add_row(mk_flush(), 1'b1, 0, '0);
        add_row(mk_pair(16'h0000, 16'h0000, 1'b1), 1'b1, 1, mk_verdict(1'b1));
        add_row(mk_pair(16'h7FFF, 16'h7FFF, 1'b1), 1'b1, 1, mk_verdict(1'b1));
        add_row(mk_pair(16'h8000, 16'h8000, 1'b1), 1'b1, 1, mk_verdict(1'b1));
        add_row(mk_pair(16'h7FFF, 16'h8000, 1'b1), 1'b1, 1, mk_verdict(1'b0));
        add_row(mk_pair(16'h8000, 16'h7FFF, 1'b0), 1'b0, 0, '0);
        add_row(mk_pair(16'h0000, 16'h0000, 1'b1), 1'b0, 0, '0);
        add_row(mk_pair(16'd100, 16'd100, 1'b0), 1'b0, 0, '0);
        add_row(mk_pair(16'd100, 16'd101, 1'b1), 1'b0, 0, '0);
        add_row(mk_pair(16'd1, 16'd0, 1'b1), 1'b0, 0, '0);
        add_row(mk_pair(16'd0, 16'hFFFF, 1'b1), 1'b0, 0, '0);
        add_row(mk_pair(16'hFFFF, 16'hFFFF, 1'b0), 1'b0, 0, '0);
        add_row(mk_pair(16'd5, 16'hFFFB, 1'b0), 1'b0, 0, '0);
        add_row(mk_flush(), 1'b0, 0, '0);
        add_row(mk_flush(), 1'b1, 0, '0);
        add_row(mk_pair(16'h7FFF, 16'h7FFF, 1'b1), 1'b0, 0, '0);
        add_row(mk_pair(16'h7FFE, 16'h7FFF, 1'b1), 1'b0, 0, '0);
        add_row(mk_flush(), 1'b0, 0, '0);

        foreach (rows[i]) begin
            send_item(rows[i].item);
            detect_step(rows[i].item);
            if (rows[i].typed) begin
                for (int j = 0; j < rows[i].n_typed; j++) begin
                    pending_results.push_back(rows[i].res);
                end
            end else begin
                push_step();
            end
        end
        wait_drained();

        program_regs(THR_RESET, 32'd0, 10'd1000);
        random_run(300);
        wait_drained();

        program_regs(17'd0, 32'd1, 10'd1);
        random_run(250);
        wait_drained();

        program_regs(17'd65536, 32'd20, 10'd500);
        random_run(300);
        wait_drained();

        // Stretch with no idling on either side.
        idle_on = 1'b0;
        program_regs(17'($urandom_range(0, 65536)), 32'($urandom_range(0, 64)),
                     10'($urandom_range(0, 1000)));
        random_run(400);
        wait_drained();
        idle_on = 1'b1;

        // A frame that ends on length alone, then a region of exactly the minimum.
        program_regs(THR_RESET, 32'd4096, 10'd999);
        send_checked(mk_flush());
        for (int k = 0; k < FRAME_MAX; k++) begin
            l = rand16();
            send_checked(mk_pair(l[15:0], l[15:0], 1'b0));
        end
        send_checked(mk_pair(16'h7FFF, 16'h8000, 1'b1));
        random_run(200);
        send_checked(mk_flush());
        wait_drained();

        program_regs(17'd1000, 32'hFFFF_FFFF, 10'd0);
        random_run(200);
        wait_drained();

        program_regs(THR_RESET, MIN_RESET, WARN_RESET);
        random_run(250);
        send_checked(mk_flush());
        wait_drained();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
